>>> design/trspm_pkg.sv
package trspm_pkg;

    // input word commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_PUSH  = 2'd2;

    // register indexes, one 64-bit register every 8 bytes
    localparam logic [2:0] REG_SCROLL_FINE   = 3'd0;
    localparam logic [2:0] REG_LAYER_ENABLES = 3'd1;
    localparam logic [2:0] REG_BG_LOW        = 3'd2;
    localparam logic [2:0] REG_BG_HIGH       = 3'd3;
    localparam logic [2:0] REG_OBJ0_LOW      = 3'd4;
    localparam logic [2:0] REG_OBJ0_HIGH     = 3'd5;
    localparam logic [2:0] REG_OBJ1_LOW      = 3'd6;
    localparam logic [2:0] REG_OBJ1_HIGH     = 3'd7;

    localparam int PAL_WORDS = 6;
    localparam logic [2:0] PAL_BG   = 3'd0;
    localparam logic [2:0] PAL_OBJ0 = 3'd2;
    localparam logic [2:0] PAL_OBJ1 = 3'd4;

    localparam int TILE_PIXELS = 8;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_PUSH = 1'b1
    } t_state;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] sprite_x;
        logic       sprite_xflip;
        logic       sprite_behind_bg;
        logic       sprite_palette_sel;
        logic [7:0] sprite_plane0;
        logic [7:0] sprite_plane1;
        logic [7:0] bg_plane0;
        logic [7:0] bg_plane1;
        logic [7:0] fetch_pos;
    } t_in_word;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic [7:0]  screen_x;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [7:0] x;
        logic       xflip;
        logic       behind;
        logic       pal;
        logic [7:0] p0;
        logic [7:0] p1;
    } t_slot;

    typedef struct packed {
        logic [2:0]                      scroll_fine;
        logic [1:0]                      layer_enables;
        logic [PAL_WORDS-1:0][63:0]      palettes;
    } t_cfg;

    // colour 0/2 in the low half, colour 1/3 in the high half
    function automatic logic [31:0] color_pick(input logic [63:0] word, input logic hi);
        color_pick = hi ? word[63:32] : word[31:0];
    endfunction

endpackage

>>> design/tile_row_sprite_pixel_mixer.sv
// channel   | direction | signals                         | word
// ----------+-----------+---------------------------------+-----------------------
// input     | in        | i_in_valid, o_in_stall          | i_in_word  (t_in_word)
// output    | out       | o_out_valid, i_out_stall        | o_out_word (t_out_word)
// config    | in/out    | psel, penable, pwrite, paddr,   | 64-bit registers at 8*i
//           |           | pwdata, prdata, pready          |
//
// start-line, load and dropped push words leave the input free for the next word
// a push is accepted, then its 8 pixels pass one by one through the
// shared mixing unit with o_in_stall high
// a full output register under i_out_stall pauses the pixel counter
// i_rst_n is synchronous, active low; sprite slot contents have no reset
module tile_row_sprite_pixel_mixer import trspm_pkg::*; #(
    parameter int SCREEN_WIDTH = 160,
    parameter int SPRITE_SLOTS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int CNT_W  = $clog2(SPRITE_SLOTS + 1);
    localparam int SLOT_W = (SPRITE_SLOTS > 1) ? $clog2(SPRITE_SLOTS) : 1;

    t_cfg        w_cfg;
    t_state      r_state;
    t_state      n_state;
    logic [CNT_W-1:0] r_count;
    // queue and pop positions always move together, so one counter serves both
    logic [7:0]  r_line_x;
    logic [7:0]  r_out_x;
    logic [2:0]  r_pix;
    logic [7:0]  r_bg0;
    logic [7:0]  r_bg1;
    t_slot       r_slots [SPRITE_SLOTS];
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        w_in_acc;
    logic        w_step;
    logic        w_drop;
    logic        w_emit;
    logic        w_last;
    logic        w_pix_end;
    logic [31:0] w_color;

    trspm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // shared pixel unit: background lookup plus sprite priority for one pixel
    trspm_mix #(
        .SPRITE_SLOTS (SPRITE_SLOTS),
        .CNT_W        (CNT_W)
    ) u_mix (
        .i_cfg       (w_cfg),
        .i_slots     (r_slots),
        .i_count     (r_count),
        .i_line_x    (r_line_x),
        .i_pix       (r_pix),
        .i_bg_plane0 (r_bg0),
        .i_bg_plane1 (r_bg1),
        .o_color     (w_color)
    );

    assign w_in_acc  = i_in_valid && !o_in_stall;
    // row start = fetch_pos - 8 + scroll_fine, dropped when negative
    assign w_drop    = (({1'b0, i_in_word.fetch_pos} + {6'd0, w_cfg.scroll_fine}) < 9'd8);
    assign w_pix_end = (r_pix == 3'(TILE_PIXELS - 1));
    // leading fine-scroll pixels are skipped, pixels past the screen dropped
    assign w_emit    = (r_line_x >= {5'd0, w_cfg.scroll_fine})
                       && (r_out_x < 8'(SCREEN_WIDTH));
    // emitted pixels form one run, so it ends at the row end or the screen edge
    assign w_last    = w_pix_end || (r_out_x == 8'(SCREEN_WIDTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_in_word.command == CMD_PUSH) && !w_drop) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (w_step && w_pix_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                w_step     = 1'b0;
            end
            ST_PUSH: begin
                o_in_stall = 1'b1;
                w_step     = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
                w_step     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_line_x    <= 8'd0;
            r_out_x     <= 8'd0;
            r_pix       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                case (i_in_word.command)
                    CMD_START: begin
                        r_line_x <= 8'd0;
                        r_out_x  <= 8'd0;
                        r_count  <= '0;
                    end
                    CMD_LOAD: begin
                        if (r_count < CNT_W'(SPRITE_SLOTS)) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    CMD_PUSH: begin
                        r_pix <= 3'd0;
                        // a dropped row still empties the sprite slots
                        if (w_drop) begin
                            r_count <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (w_step) begin
                r_pix <= r_pix + 3'd1;
                if (r_line_x != 8'hFF) begin
                    r_line_x <= r_line_x + 8'd1;
                end
                if (w_emit) begin
                    r_out_x <= r_out_x + 8'd1;
                end
                if (w_pix_end) begin
                    r_count <= '0;
                end
            end
            // output register: load on an emitted pixel, else empty when taken
            if (w_step && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_word.command == CMD_LOAD)
                && (r_count < CNT_W'(SPRITE_SLOTS))) begin
            r_slots[r_count[SLOT_W-1:0]] <= '{
                x:      i_in_word.sprite_x,
                xflip:  i_in_word.sprite_xflip,
                behind: i_in_word.sprite_behind_bg,
                pal:    i_in_word.sprite_palette_sel,
                p0:     i_in_word.sprite_plane0,
                p1:     i_in_word.sprite_plane1
            };
        end
        if (w_in_acc && (i_in_word.command == CMD_PUSH)) begin
            r_bg0 <= i_in_word.bg_plane0;
            r_bg1 <= i_in_word.bg_plane1;
        end
        if (w_step && w_emit) begin
            r_out_word.pixel_color <= w_color;
            r_out_word.screen_x    <= r_out_x;
            r_out_word.last        <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // sprite fill never passes the slot count
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SPRITE_SLOTS))
        else $error("sprite count above slot count");

    // a finished push leaves the sprite slots empty
    a_push_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_pix_end) |=> (r_count == '0))
        else $error("sprite slots not cleared after push");

    // emitted pixels stay on screen
    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.screen_x < 8'(SCREEN_WIDTH)))
        else $error("pixel emitted past screen width");

    // the pixel counter only runs during a push
    a_pix_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> $stable(r_line_x) || $past(w_in_acc))
        else $error("line position moved while idle");

endmodule

>>> design/trspm_regs.sv
module trspm_regs import trspm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [2:0]                 r_scroll_fine;
    logic [1:0]                 r_layer_enables;
    logic [PAL_WORDS-1:0][63:0] r_palettes;
    logic                       w_wr;
    logic [2:0]                 w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scroll_fine   <= 3'd0;
            r_layer_enables <= 2'd3;
            r_palettes      <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_SCROLL_FINE:   r_scroll_fine   <= pwdata[2:0];
                REG_LAYER_ENABLES: r_layer_enables <= pwdata[1:0];
                REG_BG_LOW:        r_palettes[0]   <= pwdata;
                REG_BG_HIGH:       r_palettes[1]   <= pwdata;
                REG_OBJ0_LOW:      r_palettes[2]   <= pwdata;
                REG_OBJ0_HIGH:     r_palettes[3]   <= pwdata;
                REG_OBJ1_LOW:      r_palettes[4]   <= pwdata;
                REG_OBJ1_HIGH:     r_palettes[5]   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_SCROLL_FINE:   prdata = {61'd0, r_scroll_fine};
            REG_LAYER_ENABLES: prdata = {62'd0, r_layer_enables};
            REG_BG_LOW:        prdata = r_palettes[0];
            REG_BG_HIGH:       prdata = r_palettes[1];
            REG_OBJ0_LOW:      prdata = r_palettes[2];
            REG_OBJ0_HIGH:     prdata = r_palettes[3];
            REG_OBJ1_LOW:      prdata = r_palettes[4];
            REG_OBJ1_HIGH:     prdata = r_palettes[5];
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.scroll_fine   = r_scroll_fine;
    assign o_cfg.layer_enables = r_layer_enables;
    assign o_cfg.palettes      = r_palettes;

endmodule

>>> design/trspm_mix.sv
module trspm_mix import trspm_pkg::*; #(
    parameter int SPRITE_SLOTS = 3,
    parameter int CNT_W        = 2
) (
    input  t_cfg             i_cfg,
    input  t_slot            i_slots [SPRITE_SLOTS],
    input  logic [CNT_W-1:0] i_count,
    input  logic [7:0]       i_line_x,
    input  logic [2:0]       i_pix,
    input  logic [7:0]       i_bg_plane0,
    input  logic [7:0]       i_bg_plane1,
    output logic [31:0]      o_color
);

    logic [2:0]  w_bit;
    logic [1:0]  w_bg_idx;
    logic [1:0]  w_bg_eff;
    logic [31:0] w_bg_color;
    logic [9:0]  w_off  [SPRITE_SLOTS];
    logic [2:0]  w_sel  [SPRITE_SLOTS];
    logic [1:0]  w_sidx [SPRITE_SLOTS];
    logic [SPRITE_SLOTS-1:0] w_hit;
    logic [1:0]  w_win_idx;
    logic        w_win_pal;
    logic [2:0]  w_word;

    // msb is the leftmost pixel
    assign w_bit      = ~i_pix;
    assign w_bg_idx   = {i_bg_plane1[w_bit], i_bg_plane0[w_bit]};
    assign w_bg_eff   = i_cfg.layer_enables[0] ? w_bg_idx : 2'd0;
    assign w_bg_color = color_pick(i_cfg.palettes[PAL_BG + {2'd0, w_bg_eff[1]}], w_bg_eff[0]);

    // offset = line_x - (sprite_x - 8 + scroll), negative shows in bit 9
    always_comb begin
        for (int i = 0; i < SPRITE_SLOTS; i++) begin
            w_off[i]  = {2'd0, i_line_x} + 10'd8 - {7'd0, i_cfg.scroll_fine}
                        - {2'd0, i_slots[i].x};
            w_sel[i]  = i_slots[i].xflip ? w_off[i][2:0] : ~w_off[i][2:0];
            w_sidx[i] = {i_slots[i].p1[w_sel[i]], i_slots[i].p0[w_sel[i]]};
            w_hit[i]  = (CNT_W'(i) < i_count) && (w_off[i][9:3] == 7'd0)
                        && (w_sidx[i] != 2'd0)
                        && !(i_slots[i].behind && (w_bg_idx != 2'd0));
        end
    end

    // first slot in load order wins
    always_comb begin
        w_win_idx = 2'd0;
        w_win_pal = 1'b0;
        for (int i = SPRITE_SLOTS - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_win_idx = w_sidx[i];
                w_win_pal = i_slots[i].pal;
            end
        end
    end

    assign w_word = (w_win_pal ? PAL_OBJ1 : PAL_OBJ0) + {2'd0, w_win_idx[1]};

    always_comb begin
        if (i_cfg.layer_enables[1] && (w_hit != '0)) begin
            o_color = color_pick(i_cfg.palettes[w_word], w_win_idx[0]);
        end else begin
            o_color = w_bg_color;
        end
    end

endmodule

>>> bench/trspm_pixel_checker.sv
`timescale 1ns / 100ps
module trspm_pixel_checker import trspm_pkg::*; #(
    parameter int SCREEN_WIDTH = 160,
    parameter int SPRITE_SLOTS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_word    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_word   i_out_word,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [5:0]  i_paddr,
    input  logic [63:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int REPORT_LIMIT = 10;

    // shadow of the register file
    logic [2:0]  scroll_fine;
    logic [1:0]  layer_enables;
    logic [63:0] palette_words [PAL_WORDS];

    // line state
    int unsigned queued_x;
    int unsigned popped_x;
    int unsigned output_x;
    int unsigned slot_count;
    t_slot       slots [SPRITE_SLOTS];

    t_out_word   expected_pixels [$];
    int          fail_count = 0;

    function automatic logic [31:0] palette_color(input int base, input logic [1:0] idx);
        logic [63:0] pair;
        pair = palette_words[base + int'(idx[1])];
        return idx[0] ? pair[63:32] : pair[31:0];
    endfunction

    // first opaque sprite in load order whose priority lets it through
    function automatic logic [31:0] sprite_overlay(input logic [31:0] under,
                                                   input logic [1:0] bg_idx);
        logic [31:0] color;
        logic [1:0]  idx;
        int          pos;
        int          off;
        int          bit_sel;
        bit          hit;
        color = under;
        hit   = 1'b0;
        for (int i = 0; i < SPRITE_SLOTS; i++) begin
            if (!hit && i < slot_count) begin
                pos = int'(slots[i].x) - 8 + int'(scroll_fine);
                off = int'(queued_x) - pos;
                if (off >= 0 && off <= 7) begin
                    bit_sel = slots[i].xflip ? off : 7 - off;
                    idx = {slots[i].p1[bit_sel], slots[i].p0[bit_sel]};
                    if (idx != 2'd0 && !(slots[i].behind && bg_idx != 2'd0)) begin
                        color = palette_color(slots[i].pal ? PAL_OBJ1 : PAL_OBJ0, idx);
                        hit   = 1'b1;
                    end
                end
            end
        end
        return color;
    endfunction

    task automatic mix_tile_row(input t_in_word w);
        int          row_start;
        int          b;
        logic [1:0]  idx;
        logic [31:0] color;
        t_out_word   held;
        bit          have_held;
        row_start = int'(w.fetch_pos) - 8 + int'(scroll_fine);
        have_held = 1'b0;
        held      = '0;
        if (row_start >= 0) begin
            for (int i = 0; i < TILE_PIXELS; i++) begin
                b     = 7 - i;
                idx   = {w.bg_plane1[b], w.bg_plane0[b]};
                color = palette_color(PAL_BG, layer_enables[0] ? idx : 2'd0);
                if (layer_enables[1])
                    color = sprite_overlay(color, idx);
                if (queued_x < 255)
                    queued_x++;
                if (popped_x >= scroll_fine && output_x < SCREEN_WIDTH) begin
                    if (have_held)
                        expected_pixels.push_back(held);
                    held.pixel_color = color;
                    held.screen_x    = 8'(output_x);
                    held.last        = 1'b0;
                    have_held        = 1'b1;
                    output_x++;
                end
                if (popped_x < 255)
                    popped_x++;
            end
            if (have_held) begin
                held.last = 1'b1;
                expected_pixels.push_back(held);
            end
        end
        slot_count = 0;
    endtask

    task automatic take_word(input t_in_word w);
        case (w.command)
            CMD_START: begin
                queued_x   = 0;
                popped_x   = 0;
                output_x   = 0;
                slot_count = 0;
            end
            CMD_LOAD: begin
                if (slot_count < SPRITE_SLOTS) begin
                    slots[slot_count] = {w.sprite_x, w.sprite_xflip, w.sprite_behind_bg,
                                         w.sprite_palette_sel, w.sprite_plane0,
                                         w.sprite_plane1};
                    slot_count++;
                end
            end
            CMD_PUSH: mix_tile_row(w);
            default: ;
        endcase
    endtask

    task automatic check_pixel(input t_out_word got);
        t_out_word want;
        if (expected_pixels.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected pixel: color %h x %0d last %b",
                         got.pixel_color, got.screen_x, got.last);
        end else begin
            want = expected_pixels.pop_front();
            if (got !== want) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display({"pixel mismatch: expected color %h x %0d last %b,",
                              " got color %h x %0d last %b"},
                             want.pixel_color, want.screen_x, want.last,
                             got.pixel_color, got.screen_x, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            scroll_fine   = 3'd0;
            layer_enables = 2'd3;
            for (int i = 0; i < PAL_WORDS; i++)
                palette_words[i] = '0;
            queued_x   = 0;
            popped_x   = 0;
            output_x   = 0;
            slot_count = 0;
            expected_pixels.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[5:3])
                    REG_SCROLL_FINE:   scroll_fine   = i_pwdata[2:0];
                    REG_LAYER_ENABLES: layer_enables = i_pwdata[1:0];
                    default: palette_words[int'(i_paddr[5:3]) - int'(REG_BG_LOW)] = i_pwdata;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                take_word(i_in_word);
            if (i_out_valid && !i_out_stall)
                check_pixel(i_out_word);
        end
        o_pending    <= expected_pixels.size();
        o_fail_count <= fail_count;
    end

endmodule

>>> bench/tb_tile_row_sprite_pixel_mixer.sv
`timescale 1ns / 100ps
module tb_tile_row_sprite_pixel_mixer import trspm_pkg::*; ();

    // cycles with no handshake at all before the run is called hung
    localparam int IDLE_LIMIT   = 4000;
    // settle time after the last pixel, covers a push that emits nothing
    localparam int DRAIN_CYCLES = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_word   o_out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    int tx_idle_pct;
    int rx_idle_pct;
    int words_sent;
    int pending;
    int fail_count;
    int quiet_cycles = 0;

    tile_row_sprite_pixel_mixer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    trspm_pixel_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stall, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_stall <= (int'($urandom_range(0, 99)) < rx_idle_pct);
    end

    // hang detection: any accepted word, accepted pixel or register access restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAIL tile_row_sprite_pixel_mixer");
            $finish;
        end
    end

    // plane bytes lean toward all-clear and all-set rows
    function automatic logic [7:0] random_plane();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // fields the command does not use stay random
    function automatic t_in_word cmd_word(input logic [1:0] cmd);
        logic [63:0] raw;
        t_in_word    w;
        raw       = {$urandom, $urandom};
        w         = raw[$bits(t_in_word)-1:0];
        w.command = cmd;
        return w;
    endfunction

    function automatic t_in_word load_word(input logic [7:0] x, input logic flip,
                                           input logic behind, input logic pal,
                                           input logic [7:0] p0, input logic [7:0] p1);
        t_in_word w;
        w                    = cmd_word(CMD_LOAD);
        w.sprite_x           = x;
        w.sprite_xflip       = flip;
        w.sprite_behind_bg   = behind;
        w.sprite_palette_sel = pal;
        w.sprite_plane0      = p0;
        w.sprite_plane1      = p1;
        return w;
    endfunction

    function automatic t_in_word push_word(input logic [7:0] fetch, input logic [7:0] b0,
                                           input logic [7:0] b1);
        t_in_word w;
        w           = cmd_word(CMD_PUSH);
        w.fetch_pos = fetch;
        w.bg_plane0 = b0;
        w.bg_plane1 = b1;
        return w;
    endfunction

    // called and returns at a falling edge; valid stays up into the next word
    task automatic send_word(input t_in_word w);
        while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
    endtask

    // setup cycle, access cycle, then back to idle
    task automatic apb_write(input logic [2:0] reg_idx, input logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold the sender until every predicted pixel is out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // block idle: drained, plus room for a push that emits nothing
    task automatic settle();
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_view(input logic [2:0] scroll, input logic [1:0] layers);
        apb_write(REG_SCROLL_FINE, 64'(scroll));
        apb_write(REG_LAYER_ENABLES, 64'(layers));
    endtask

    // fill: 0 random colours, 1 all ones, 2 all zeros
    task automatic load_palettes(input int fill);
        logic [63:0] value;
        for (int r = int'(REG_BG_LOW); r <= int'(REG_OBJ1_HIGH); r++) begin
            case (fill)
                1:       value = '1;
                2:       value = '0;
                default: value = {$urandom, $urandom};
            endcase
            apb_write(3'(r), value);
        end
    endtask

    // one scan line: start, then per tile a few sprite loads and a push
    // sprites land around the tile being pushed so they actually overlap
    task automatic run_line(input int tiles, input bit with_sprites);
        int          loads;
        int          sx;
        logic [7:0]  fetch;
        send_word(cmd_word(CMD_START));
        for (int t = 0; t < tiles; t++) begin
            // stray word: may restart the line, load a sprite, push a row or be the unused command
            if ($urandom_range(0, 11) == 0)
                send_word(cmd_word(2'($urandom_range(0, 3))));
            loads = 0;
            if (with_sprites && $urandom_range(0, 1) == 1)
                loads = $urandom_range(1, 3);
            if (with_sprites && $urandom_range(0, 9) == 0)
                loads = 4;
            for (int k = 0; k < loads; k++) begin
                sx = t * 8 + 1 + int'($urandom_range(0, 14));
                send_word(load_word(8'(sx), 1'($urandom), 1'($urandom), 1'($urandom),
                                    random_plane(), random_plane()));
            end
            if ($urandom_range(0, 7) == 0)
                fetch = 8'($urandom);
            else
                fetch = ((t + 1) * 8 < 255) ? 8'((t + 1) * 8) : 8'd255;
            send_word(push_word(fetch, random_plane(), random_plane()));
        end
        if ($urandom_range(0, 3) == 0)
            drain_results();
    endtask

    // mostly short lines, now and then one long enough to hit the right edge
    task automatic run_phase(input int target);
        while (words_sent < target) begin
            if ($urandom_range(0, 3) == 0)
                run_line($urandom_range(19, 22), 1'b1);
            else
                run_line($urandom_range(1, 6), 1'b1);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_word    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        words_sent   = 0;
        tx_idle_pct  = 32;
        rx_idle_pct  = 65;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: no scroll, both layers, distinct colours
        set_view(3'd0, 2'd3);
        load_palettes(0);
        send_word(cmd_word(CMD_START));
        // sprite at screen 0, solid colour 1
        send_word(load_word(8'd8, 1'b0, 1'b0, 1'b0, 8'hFF, 8'h00));
        // flipped, behind background, palette one, overlaps the first
        send_word(load_word(8'd10, 1'b1, 1'b1, 1'b1, 8'hA5, 8'h3C));
        // fully left of the screen
        send_word(load_word(8'd0, 1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF));
        // slots full, dropped
        send_word(load_word(8'd255, 1'b0, 1'b0, 1'b1, 8'hFF, 8'hFF));
        send_word(push_word(8'd8, 8'h0F, 8'h33));
        // row left of the screen: no pixels, slots cleared
        send_word(push_word(8'd0, 8'hFF, 8'hFF));
        // unused command
        send_word(cmd_word(2'd3));
        // behind-background sprite over background colour 0
        send_word(load_word(8'd16, 1'b0, 1'b1, 1'b0, 8'h00, 8'hFF));
        send_word(push_word(8'd16, 8'h00, 8'h00));
        send_word(load_word(8'd255, 1'b1, 1'b0, 1'b0, 8'hFF, 8'hFF));
        send_word(push_word(8'd255, 8'hFF, 8'hFF));
        send_word(push_word(8'd24, 8'hFF, 8'h00));
        settle();

        // directed: full fine scroll, background off, sprites on
        set_view(3'd7, 2'd2);
        send_word(cmd_word(CMD_START));
        send_word(load_word(8'd1, 1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF));
        // start lands at -1: dropped
        send_word(push_word(8'd0, 8'hAA, 8'h55));
        send_word(load_word(8'd1, 1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF));
        // seven leading pixels skipped; behind sprite loses to raw bg index
        send_word(push_word(8'd1, 8'hAA, 8'h55));
        send_word(push_word(8'd9, 8'h00, 8'h00));
        settle();

        // random, sender idles less than the receiver
        load_palettes(0);
        set_view(3'd7, 2'd3);
        run_phase(30);
        settle();

        // roles swapped, all-ones colours, background off
        tx_idle_pct = 65;
        rx_idle_pct = 32;
        load_palettes(1);
        set_view(3'd0, 2'd2);
        run_phase(45);
        settle();

        // no idling, sprites off
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_palettes(0);
        set_view(3'd3, 2'd1);
        run_phase(60);
        settle();

        // both layers off, then a line long enough to pin the x counters
        load_palettes(0);
        set_view(3'($urandom_range(1, 6)), 2'd0);
        run_line(2, 1'b1);
        run_line(34, 1'b0);
        settle();
        set_view(3'd5, 2'd3);
        run_line(3, 1'b1);

        settle();
        if (fail_count == 0)
            $display("PASS tile_row_sprite_pixel_mixer");
        else
            $display("FAIL tile_row_sprite_pixel_mixer");
        $finish;
    end

endmodule
